@@ hw/rtl/bf3_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_pkg
// shared types, constants and the divisor reciprocal table of the 3x3 filter
// ----------------------------------------------------------------------------
package bf3_pkg;

  localparam int unsigned MaxWidthDef  = 1024;
  localparam int unsigned MaxHeightDef = 1024;

  localparam int unsigned CfgW   = 11;  // configuration data width
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned DimW   = 14;  // holds any clamped dimension
  localparam int unsigned PixW   = 8;
  localparam int unsigned PosW   = 10;  // row and column of a result
  localparam int unsigned SumW   = 12;  // nine pixels
  localparam int unsigned RcpW   = 17;
  localparam int unsigned RcpSh  = 16;

  localparam logic [CfgIdxW-1:0] RegFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegFrameHeight = 2'd1;

  localparam logic [CfgW-1:0] FrameWidthRst  = 11'd640;
  localparam logic [CfgW-1:0] FrameHeightRst = 11'd480;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       accept;
    logic       shift;
    logic       load;
    logic [1:0] sel;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic [3:0] mask;
    logic       s1_free;
  } sts_t;

  // reciprocal of the neighbour count, scaled by 2^16, exact for sums below 2^12
  function automatic logic [RcpW-1:0] bf3_rcp(input logic [1:0] rlo, input logic [1:0] clo);
    logic [3:0] cnt;
    logic [RcpW-1:0] r;
    cnt = {2'b00, 2'd3 - rlo} * {2'b00, 2'd3 - clo};
    case (cnt)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd6:    r = 17'd10923;
      4'd9:    r = 17'd7282;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/bf3_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_ctrl
// sequencer: takes an item, updates the window, then issues its results
// ----------------------------------------------------------------------------
module bf3_ctrl
  import bf3_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e     state_q, state_d;
  logic [3:0] pend_q, pend_d;
  logic [3:0] rest;
  logic [1:0] sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  // lowest pending result goes first
  always_comb begin
    if (pend_q[0]) begin
      sel = 2'd0;
    end else if (pend_q[1]) begin
      sel = 2'd1;
    end else if (pend_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    rest = pend_q & ~(4'd1 << sel);
  end

  always_comb begin
    in_stall_o  = (state_q != ST_IDLE);
    cmd_o       = '0;
    cmd_o.sel   = sel;
    cmd_o.last  = (rest == 4'd0);
    case (state_q)
      ST_IDLE:  cmd_o.accept = in_valid_i;
      ST_SHIFT: cmd_o.shift = 1'b1;
      ST_EMIT:  cmd_o.load = sts_i.s1_free;
      default:  cmd_o = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SHIFT;
      end
      ST_SHIFT: begin
        pend_d  = sts_i.mask;
        state_d = (sts_i.mask == 4'd0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.s1_free) begin
          pend_d = rest;
          if (rest == 4'd0) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ hw/rtl/bf3_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bf3_datapath
// geometry, position counters, line stores, window, sum and divide stages
// ----------------------------------------------------------------------------
module bf3_datapath
  import bf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [CfgW-1:0]     cfg_data_i,
  input  wire  [PixW-1:0]     pixel_in_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [PixW-1:0]     smoothed_o,
  output logic [PosW-1:0]     out_row_o,
  output logic [PosW-1:0]     out_col_o,
  output logic                last_of_item_o,
  output logic                end_of_frame_o
);

  localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [DimW-1:0] MaxW = DimW'(MAX_WIDTH);
  localparam logic [DimW-1:0] MaxH = DimW'(MAX_HEIGHT);

  logic [CfgW-1:0] fw_q, fh_q;
  logic [DimW-1:0] w_ext, h_ext, wm1_ext, hm1_ext;
  logic [CW-1:0]   wm1;
  logic [RW-1:0]   hm1;
  logic [CW-1:0]   col_q;
  logic [RW-1:0]   row_q;
  logic            lcol, lrow;

  logic [PixW-1:0] upper_mem [MAX_WIDTH];
  logic [PixW-1:0] mid_mem [MAX_WIDTH];
  logic [PixW-1:0] up_rd_q, mid_rd_q, px_q;
  logic [CW-1:0]   ic_q;
  logic [RW-1:0]   ir_q;
  logic            ilcol_q, ilrow_q;
  logic [PixW-1:0] win_q [9];

  logic [DimW-1:0] ir_ext, ic_ext;
  logic [1:0]      rlo, clo;
  logic [SumW-1:0] sum;

  logic            s1_vld_q;
  logic [SumW-1:0] sum_q;
  logic [RcpW-1:0] rcp_q;
  logic [PosW-1:0] s1_row_q, s1_col_q;
  logic            s1_last_q, s1_eof_q;
  logic            out_ready, s1_go;
  logic [SumW+RcpW-1:0] prod;

  // clamp geometry: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    w_ext = DimW'(fw_q);
    h_ext = DimW'(fh_q);
    if (w_ext == '0) w_ext = DimW'(1);
    else if (w_ext > MaxW) w_ext = MaxW;
    if (h_ext == '0) h_ext = DimW'(1);
    else if (h_ext > MaxH) h_ext = MaxH;
    wm1_ext = w_ext - DimW'(1);
    hm1_ext = h_ext - DimW'(1);
  end
  assign wm1  = wm1_ext[CW-1:0];
  assign hm1  = hm1_ext[RW-1:0];
  assign lcol = (col_q == wm1);
  assign lrow = (row_q == hm1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= FrameWidthRst;
      fh_q  <= FrameHeightRst;
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i && (cfg_idx_i == RegFrameWidth || cfg_idx_i == RegFrameHeight)) begin
      if (cfg_idx_i == RegFrameWidth) fw_q <= cfg_data_i;
      else fh_q <= cfg_data_i;
      col_q <= '0;
      row_q <= '0;
    end else if (cmd_i.accept) begin
      if (lcol) begin
        col_q <= '0;
        row_q <= lrow ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // line stores: read on accept, written back during the window update
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      up_rd_q  <= upper_mem[col_q];
      mid_rd_q <= mid_mem[col_q];
      px_q     <= pixel_in_i;
      ic_q     <= col_q;
      ir_q     <= row_q;
      ilcol_q  <= lcol;
      ilrow_q  <= lrow;
    end
    if (cmd_i.shift) begin
      upper_mem[ic_q] <= mid_rd_q;
      mid_mem[ic_q]   <= px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (cmd_i.shift) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2] <= up_rd_q;
      win_q[5] <= mid_rd_q;
      win_q[8] <= px_q;
    end
  end

  // results: 0/1 finish row r-1, 2/3 finish row r on the last row
  assign sts_o.mask = {ilrow_q & ilcol_q, ilrow_q & (ic_q != '0),
                       (ir_q != '0) & ilcol_q, (ir_q != '0) & (ic_q != '0)};
  assign ir_ext = DimW'(ir_q);
  assign ic_ext = DimW'(ic_q);

  always_comb begin
    if (cmd_i.sel[1]) rlo = (ir_ext >= DimW'(1)) ? 2'd1 : 2'd2;
    else rlo = (ir_ext >= DimW'(2)) ? 2'd0 : 2'd1;
    if (cmd_i.sel[0]) clo = (ic_ext >= DimW'(1)) ? 2'd1 : 2'd2;
    else clo = (ic_ext >= DimW'(2)) ? 2'd0 : 2'd1;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (i >= int'(rlo) && j >= int'(clo)) sum = sum + SumW'(win_q[i*3+j]);
      end
    end
  end

  assign out_ready     = !out_valid_o || !out_stall_i;
  assign s1_go         = s1_vld_q && out_ready;
  assign sts_o.s1_free = !s1_vld_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (cmd_i.load) begin
      s1_vld_q <= 1'b1;
    end else if (s1_go) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sum_q     <= sum;
      rcp_q     <= bf3_rcp(rlo, clo);
      s1_row_q  <= cmd_i.sel[1] ? ir_ext[PosW-1:0] : 10'(ir_ext - DimW'(1));
      s1_col_q  <= cmd_i.sel[0] ? ic_ext[PosW-1:0] : 10'(ic_ext - DimW'(1));
      s1_last_q <= cmd_i.last;
      s1_eof_q  <= cmd_i.last && (cmd_i.sel == 2'd3);
    end
  end

  assign prod = (SumW+RcpW)'(sum_q) * (SumW+RcpW)'(rcp_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ready) begin
      out_valid_o <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      smoothed_o     <= prod[RcpSh+PixW-1:RcpSh];
      out_row_o      <= s1_row_q;
      out_col_o      <= s1_col_q;
      last_of_item_o <= s1_last_q;
      end_of_frame_o <= s1_eof_q;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/box_filter_3x3_edge_average.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// box_filter_3x3_edge_average
// 3x3 mean filter over a raster pixel stream, edges average in-frame pixels
// ----------------------------------------------------------------------------
// pixels enter on in_valid_i/in_stall_o in raster order; results leave on
// out_valid_o/out_stall_i with their row and column, last_of_item_o on the
// last result of an input pixel and end_of_frame_o on the final one of a frame.
// a pixel passes the line store read and the window update, then releases its
// results one per cycle through the sum stage while the sum stage is free; no
// new pixel is taken until the last of them is issued. the first result of a
// pixel follows its acceptance through the window update, sum stage and output
// register. frame_width (index 0) and frame_height (index 1) are written on
// the cfg port by the user only while the block is idle, which the block does
// not enforce; a write restarts the frame at row 0, column 0. reset loads
// 640x480 and clears the window; line stores need no clearing. when the
// receiver stalls the output register and the sum stage hold and the sequencer
// waits, so in_stall_o stays high until the last result enters the sum stage.
// ----------------------------------------------------------------------------
module box_filter_3x3_edge_average
  import bf3_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = MaxHeightDef
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 cfg_we_i,
  input  wire  [CfgIdxW-1:0]  cfg_idx_i,
  input  wire  [CfgW-1:0]     cfg_data_i,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  wire  [PixW-1:0]     pixel_in_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output logic [PixW-1:0]     smoothed_o,
  output logic [PosW-1:0]     out_row_o,
  output logic [PosW-1:0]     out_col_o,
  output logic                last_of_item_o,
  output logic                end_of_frame_o
);

  cmd_t cmd;
  sts_t sts;

  bf3_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bf3_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .pixel_in_i     (pixel_in_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .smoothed_o     (smoothed_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .last_of_item_o (last_of_item_o),
    .end_of_frame_o (end_of_frame_o)
  );

endmodule
`default_nettype wire
